/* hw/rtl/htp_pkg.sv */
// htp_pkg: constants, widths and the CORDIC arctangent table for the heading tracker.
// No dependencies; used by heading_tracker_to_point.
`timescale 1ns / 1ps

package htp_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 24;

    localparam int TABLE_LEN   = 24;
    localparam int SCALE_SHIFT = 16;
    localparam int OUT_BITS    = 16;
    localparam int GAIN_BITS   = 16;
    localparam int DT_BITS     = 16;
    localparam int Z_BITS      = 32;
    localparam int MUL_BITS    = 32;
    localparam int PROD_SHIFT  = 24;

    localparam int STEP_COUNT = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int IDX_BITS   = $clog2(TABLE_LEN);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int VEC_BITS   = COORD_BITS + SCALE_SHIFT + 4;

    localparam int IN_BITS  = ((2 * COORD_BITS + DT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA = ((2 * OUT_BITS + 7) / 8) * 8;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_BITS-1:0] atan_entry(input logic [IDX_BITS-1:0] idx);
        logic [Z_BITS-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/heading_tracker_to_point.sv */
// heading_tracker_to_point: CORDIC atan2 bearing and proportional heading follower.
// Depends on htp_pkg.
`timescale 1ns / 1ps

// Each input beat carries a target point and a time step; the block returns one beat with the
// updated heading and the bearing from the configured origin to the target (16-bit binary
// angles, 65536 = full turn). Each item passes through up to 16 iterations of the shared
// CORDIC add/shift unit (stopping early when the vector lies on or lands exactly on the x axis),
// then two passes through one 32x32 multiplier (gain times step, then error magnitude times that
// product) and an update step, which waits while the output register still holds an
// unaccepted beat. s_tready is high only while idle, so a new item is taken only after the
// last one has left the update step; a finished result waits in the output register while the
// next item is taken.
// Registers: 0x0 origin_x, 0x4 origin_y, 0x8 follow_gain (Q8.8, reset 1280).
module heading_tracker_to_point (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htp_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [htp_pkg::DATA_BITS-1:0]  pwdata,
    output logic [htp_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [htp_pkg::IN_BITS-1:0]    s_tdata,  // target_x, target_y, time_step
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [htp_pkg::OUT_DATA-1:0]   m_tdata   // heading, bearing
);

    localparam int CB = htp_pkg::COORD_BITS;
    localparam int AB = htp_pkg::ANGLE_BITS;
    localparam int VB = htp_pkg::VEC_BITS;
    localparam int DB = htp_pkg::DIFF_BITS;
    localparam int MB = htp_pkg::MUL_BITS;
    localparam int ZB = htp_pkg::Z_BITS;
    localparam int OB = htp_pkg::OUT_BITS;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_GAIN     = 2'd2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ITER = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;

    localparam logic [ZB-1:0] HALF_TURN = {1'b1, {(ZB-1){1'b0}}};

    // control and state
    logic [2:0]                     state_reg, state_next;
    logic [htp_pkg::IDX_BITS-1:0]   idx_reg, idx_next;
    logic [CB-1:0]                  origin_x_reg, origin_y_reg;
    logic [htp_pkg::GAIN_BITS-1:0]  gain_reg;
    logic [AB-1:0]                  heading_reg, heading_next;
    logic                           m_valid_reg, m_valid_next;

    // datapath
    logic signed [VB-1:0]           x_reg, x_next, y_reg, y_next;
    logic [ZB-1:0]                  z_reg, z_next;
    logic [htp_pkg::DT_BITS-1:0]    dt_reg, dt_next;
    logic [AB-1:0]                  mag_reg, mag_next;
    logic                           neg_reg, neg_next;
    logic [2*MB-1:0]                prod_reg, prod_next;
    logic [OB-1:0]                  out_head_reg, out_head_next;
    logic [OB-1:0]                  out_bear_reg, out_bear_next;

    logic                           cfg_wr;
    logic                           in_fire;
    logic                           out_free;
    logic signed [DB-1:0]           dx, dy, dxa, dya;
    logic signed [VB-1:0]           xs, ys;
    logic [AB-1:0]                  bearing, err;
    logic [MB-1:0]                  mul_a, mul_b;
    logic [2*MB-1:0]                mul_out;
    logic [AB-1:0]                  delta;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = htp_pkg::OUT_DATA'({out_bear_reg, out_head_reg});

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ORIGIN_X: prdata = htp_pkg::DATA_BITS'(origin_x_reg);
            REG_ORIGIN_Y: prdata = htp_pkg::DATA_BITS'(origin_y_reg);
            REG_GAIN:     prdata = htp_pkg::DATA_BITS'(gain_reg);
            default:      prdata = '0;
        endcase
    end

    assign dx  = $signed({1'b0, s_tdata[CB-1:0]}) - $signed({1'b0, origin_x_reg});
    assign dy  = $signed({1'b0, s_tdata[2*CB-1:CB]}) - $signed({1'b0, origin_y_reg});
    assign dxa = dx[DB-1] ? -dx : dx;
    assign dya = dx[DB-1] ? -dy : dy;

    // shared shift unit
    assign xs = x_reg >>> idx_reg;
    assign ys = y_reg >>> idx_reg;

    assign bearing = z_reg[ZB-1 -: AB];
    assign err     = bearing - heading_reg;
    assign delta   = prod_reg[htp_pkg::PROD_SHIFT +: AB];

    // shared multiplier: gain * dt, then |err| * (gain * dt)
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = MB'(mag_reg);
            mul_b = prod_reg[MB-1:0];
        end
        else
        begin
            mul_a = MB'(gain_reg);
            mul_b = MB'(dt_reg);
        end
    end

    assign mul_out = (2*MB)'(mul_a) * (2*MB)'(mul_b);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        heading_next  = heading_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        dt_next       = dt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        out_head_next = out_head_reg;
        out_bear_next = out_bear_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = {{(VB-DB){dxa[DB-1]}}, dxa} <<< htp_pkg::SCALE_SHIFT;
                    y_next     = {{(VB-DB){dya[DB-1]}}, dya} <<< htp_pkg::SCALE_SHIFT;
                    z_next     = dx[DB-1] ? HALF_TURN : '0;
                    dt_next    = s_tdata[2*CB +: htp_pkg::DT_BITS];
                    idx_next   = '0;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (y_reg == '0)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    if (y_reg > 0)
                    begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + htp_pkg::atan_entry(idx_reg);
                    end
                    else
                    begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - htp_pkg::atan_entry(idx_reg);
                    end
                    if (idx_reg == htp_pkg::IDX_BITS'(htp_pkg::STEP_COUNT - 1))
                        state_next = ST_ERR;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_ERR:
            begin
                neg_next   = err[AB-1];
                mag_next   = err[AB-1] ? -err : err;
                prod_next  = mul_out;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_out;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    heading_next  = neg_reg ? heading_reg - delta : heading_reg + delta;
                    out_head_next = heading_next[AB-1 -: OB];
                    out_bear_next = bearing[AB-1 -: OB];
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            heading_reg  <= '0;
            m_valid_reg  <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            gain_reg     <= htp_pkg::GAIN_BITS'(1280);
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            heading_reg <= heading_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_ORIGIN_X: origin_x_reg <= pwdata[CB-1:0];
                    REG_ORIGIN_Y: origin_y_reg <= pwdata[CB-1:0];
                    REG_GAIN:     gain_reg     <= pwdata[htp_pkg::GAIN_BITS-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        dt_reg       <= dt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        out_head_reg <= out_head_next;
        out_bear_reg <= out_bear_next;
    end

endmodule

/* verif/heading_tracker_checker.sv */
// heading_tracker_checker: watches the config and stream ports of heading_tracker_to_point,
// predicts heading and bearing per beat, and counts mismatches. Depends on htp_pkg.
`timescale 1ns / 1ps

package htp_tb_pkg;

    localparam logic [htp_pkg::ADDR_BITS-1:0] ADDR_ORIGIN_X    = 4'h0;
    localparam logic [htp_pkg::ADDR_BITS-1:0] ADDR_ORIGIN_Y    = 4'h4;
    localparam logic [htp_pkg::ADDR_BITS-1:0] ADDR_FOLLOW_GAIN = 4'h8;

endpackage

module heading_tracker_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htp_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [htp_pkg::DATA_BITS-1:0]  pwdata,
    input  logic                           pready,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [htp_pkg::IN_BITS-1:0]    s_tdata,  // target_x, target_y, time_step
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [htp_pkg::OUT_DATA-1:0]   m_tdata,  // heading, bearing
    output int                             fail_count,
    output int                             pending_count
);

    localparam int CW = htp_pkg::COORD_BITS;
    localparam int AW = htp_pkg::ANGLE_BITS;
    localparam int OW = htp_pkg::OUT_BITS;

    typedef struct packed {
        logic [OW-1:0] bearing;
        logic [OW-1:0] heading;
    } track_beat_t;

    logic [CW-1:0] origin_x;
    logic [CW-1:0] origin_y;
    logic [15:0]   follow_gain;
    logic [AW-1:0] heading_acc;
    track_beat_t   track_fifo[$];
    int            mismatches = 0;

    // arctangent of 2^-n in 2^-32 turn
    function automatic logic [31:0] atan_turn(input int n);
        case (n)
            0:       return 32'd536870912;
            1:       return 32'd316933406;
            2:       return 32'd167458907;
            3:       return 32'd85004756;
            4:       return 32'd42667331;
            5:       return 32'd21354465;
            6:       return 32'd10679838;
            7:       return 32'd5340245;
            8:       return 32'd2670163;
            9:       return 32'd1335087;
            10:      return 32'd667544;
            11:      return 32'd333772;
            12:      return 32'd166886;
            13:      return 32'd83443;
            14:      return 32'd41722;
            15:      return 32'd20861;
            16:      return 32'd10430;
            17:      return 32'd5215;
            18:      return 32'd2608;
            19:      return 32'd1304;
            20:      return 32'd652;
            21:      return 32'd326;
            22:      return 32'd163;
            23:      return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [AW-1:0] point_bearing(input longint dx, input longint dy);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] ang;
        bit          on_axis;
        ang     = '0;
        on_axis = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            return '0;
        end
        if (dx < 0)
        begin
            dx  = -dx;
            dy  = -dy;
            ang = 32'h8000_0000;
        end
        vx = dx * (longint'(1) << htp_pkg::SCALE_SHIFT);
        vy = dy * (longint'(1) << htp_pkg::SCALE_SHIFT);
        for (int n = 0; n < htp_pkg::STEP_COUNT && !on_axis; n++)
        begin
            sx = vx >>> n;
            sy = vy >>> n;
            if (vy > 0)
            begin
                vx  = vx + sy;
                vy  = vy - sx;
                ang = ang + atan_turn(n);
            end
            else if (vy < 0)
            begin
                vx  = vx - sy;
                vy  = vy + sx;
                ang = ang - atan_turn(n);
            end
            else
            begin
                on_axis = 1'b1;
            end
        end
        return ang[htp_pkg::Z_BITS-1 -: AW];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        track_beat_t   got;
        track_beat_t   want;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        logic [15:0]   dt;
        logic [AW-1:0] bearing;
        logic [AW-1:0] err;
        logic [AW-1:0] mag;
        longint        prod;
        logic [63:0]   delta;
        if (!rst_n)
        begin
            origin_x    = '0;
            origin_y    = '0;
            follow_gain = 16'd1280;
            heading_acc = '0;
            track_fifo.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    htp_tb_pkg::ADDR_ORIGIN_X:    origin_x    = pwdata[CW-1:0];
                    htp_tb_pkg::ADDR_ORIGIN_Y:    origin_y    = pwdata[CW-1:0];
                    htp_tb_pkg::ADDR_FOLLOW_GAIN: follow_gain = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (track_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = track_fifo.pop_front();
                    if (got.heading !== want.heading)
                    begin
                        $display("%0t: heading mismatch expected %h actual %h",
                                 $time, want.heading, got.heading);
                        mismatches++;
                    end
                    if (got.bearing !== want.bearing)
                    begin
                        $display("%0t: bearing mismatch expected %h actual %h",
                                 $time, want.bearing, got.bearing);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                tx      = s_tdata[CW-1:0];
                ty      = s_tdata[2*CW-1:CW];
                dt      = s_tdata[2*CW+15:2*CW];
                bearing = point_bearing(longint'(tx) - longint'(origin_x),
                                        longint'(ty) - longint'(origin_y));
                err     = bearing - heading_acc;
                mag     = err[AW-1] ? -err : err;
                prod    = longint'(mag) * longint'(follow_gain) * longint'(dt);
                delta   = prod >> htp_pkg::PROD_SHIFT;
                if (err[AW-1])
                    heading_acc = heading_acc - delta[AW-1:0];
                else
                    heading_acc = heading_acc + delta[AW-1:0];
                want.heading = heading_acc[AW-1:AW-OW];
                want.bearing = bearing[AW-1:AW-OW];
                track_fifo.insert(track_fifo.size(), want);
            end
        end
        fail_count    <= mismatches;
        pending_count <= track_fifo.size();
    end

endmodule

/* verif/heading_tracker_to_point_tb.sv */
// heading_tracker_to_point_tb: drives config writes and target beats with random stalls on
// both streams; heading_tracker_checker predicts and compares. Depends on htp_pkg.
`timescale 1ns / 1ps

module heading_tracker_to_point_tb;

    localparam int CW            = htp_pkg::COORD_BITS;
    localparam int ITEMS_PER_SEG = 267;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [htp_pkg::ADDR_BITS-1:0] paddr    = '0;
    logic [htp_pkg::DATA_BITS-1:0] pwdata   = '0;
    logic [htp_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [htp_pkg::IN_BITS-1:0]   s_tdata  = '0;  // target_x, target_y, time_step
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [htp_pkg::OUT_DATA-1:0]  m_tdata;       // heading, bearing

    int fail_count;
    int pending_count;
    int send_idle = 0;
    int recv_idle = 0;

    logic [CW-1:0] cur_origin_x = '0;
    logic [CW-1:0] cur_origin_y = '0;

    always #5 clk = ~clk;

    heading_tracker_to_point uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    heading_tracker_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic write_reg(input logic [htp_pkg::ADDR_BITS-1:0] addr, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int unsigned ox, input int unsigned oy,
                                 input int unsigned gain);
        write_reg(htp_tb_pkg::ADDR_ORIGIN_X, ox);
        write_reg(htp_tb_pkg::ADDR_ORIGIN_Y, oy);
        write_reg(htp_tb_pkg::ADDR_FOLLOW_GAIN, gain);
        cur_origin_x = CW'(ox);
        cur_origin_y = CW'(oy);
    endtask

    task automatic send_point(input int unsigned tx, input int unsigned ty, input int unsigned dt);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dt[15:0], ty[CW-1:0], tx[CW-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // lets every outstanding beat come back with the input stream quiet
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic random_point();
        int unsigned tx;
        int unsigned ty;
        int unsigned dt;
        int unsigned pick;
        tx   = $urandom_range(0, 4095);
        ty   = $urandom_range(0, 4095);
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            tx = 32'(cur_origin_x);
            ty = 32'(cur_origin_y);
        end
        else if (pick < 10)
            tx = 32'(cur_origin_x);
        else if (pick < 15)
            ty = 32'(cur_origin_y);
        case ($urandom_range(0, 9))
            0:       dt = 0;
            1:       dt = 65535;
            2:       dt = $urandom_range(0, 255);
            default: dt = $urandom_range(0, 65535);
        endcase
        send_point(tx, ty, dt);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // heading starts at zero, so a target straight behind gives a half-turn error
        apply_setting(2048, 2048, 1280);
        send_point(0, 2048, 65535);
        send_point(2048, 2048, 65535);
        send_point(4095, 2048, 0);
        send_point(2048, 4095, 65535);
        send_point(2048, 0, 65535);
        send_point(0, 0, 32768);
        send_point(4095, 4095, 1);
        send_point(0, 4095, 65535);
        send_point(4095, 0, 65535);
        send_point(2047, 2049, 65535);
        send_point(2049, 2047, 40000);
        drain();
        // maximum gain: the heading wraps past a full turn
        write_reg(htp_tb_pkg::ADDR_FOLLOW_GAIN, 65535);
        send_point(4095, 2047, 65535);
        send_point(0, 2049, 65535);
        send_point(2048, 4095, 65535);
        send_point(1, 3, 65535);
        drain();
        write_reg(htp_tb_pkg::ADDR_FOLLOW_GAIN, 0);
        send_point(100, 3000, 65535);
        send_point(3000, 100, 65535);
        drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle = 29;
                    recv_idle <= 47;
                end
                1:
                begin
                    send_idle = 47;
                    recv_idle <= 29;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle <= 0;
                end
            endcase
            case (seg)
                0:       apply_setting(0, 0, 1280);
                1:       apply_setting(4095, 4095, 65535);
                2:       apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                                       $urandom_range(0, 65535));
                3:       apply_setting(2048, 2048, 256);
                4:       apply_setting(4095, 0, $urandom_range(0, 65535));
                default: apply_setting(0, 4095, $urandom_range(0, 65535));
            endcase
            for (int n = 0; n < ITEMS_PER_SEG; n++)
                random_point();
            drain();
        end

        repeat (24) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
